### rtl/c8df_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8df_pkg
// Shared types, constants and the CRC-8 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package c8df_pkg;

  localparam int unsigned FRAME_BYTES = 17;
  localparam int unsigned STORE_BYTES = 16;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned PAY_BYTES   = 8;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(8);
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic              frame_ok;
    logic [15:0]       msg_type;
    logic [7:0]        remote_flag;
    logic [31:0]       msg_id;
    logic [LEN_W-1:0]  data_length;
    logic [63:0]       payload;
  } frame_res_t;

  // Dallas/Maxim CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

### rtl/c8df_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8df_frame
// Byte counter, running CRC and header store; unpacks a frame on its last byte.
// ----------------------------------------------------------------------------
module c8df_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          byte_in,
  output logic                frame_last,
  output c8df_pkg::frame_res_t res
);
  import c8df_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       crc_upd;
  logic [7:0]       store_r [STORE_BYTES];
  logic [LEN_W-1:0] len_clamped;
  logic [63:0]      pay;

  assign frame_last = (count_r == LAST_COUNT);
  assign crc_upd    = crc8_byte(crc_r, byte_in);

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (byte_en) begin
      if (frame_last) begin
        count_nxt = '0;
        crc_nxt   = '0;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        crc_nxt   = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= '0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && !count_r[CNT_W-1]) begin
      store_r[count_r[IDX_W-1:0]] <= byte_in;
    end
  end

  always_comb begin
    if (store_r[7] > 8'(MAX_PAYLOAD)) begin
      len_clamped = MAX_PAYLOAD;
    end else begin
      len_clamped = store_r[7][LEN_W-1:0];
    end
    for (int i = 0; i < PAY_BYTES; i++) begin
      pay[i*8 +: 8] = (LEN_W'(i) < len_clamped) ? store_r[8+i] : 8'h00;
    end
  end

  always_comb begin
    res = '0;
    if (crc_upd == 8'h00) begin
      res.frame_ok    = 1'b1;
      res.msg_type    = {store_r[0], store_r[1]};
      res.remote_flag = store_r[2];
      res.msg_id      = {store_r[3], store_r[4], store_r[5], store_r[6]};
      res.data_length = len_clamped;
      res.payload     = pay;
    end
  end

endmodule

### rtl/crc8_packet_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_deframer_core
// Collects 17-byte CRC-8 protected radio frames and unpacks their fields.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_rx_byte carries one received byte per
// transaction. Every 17th byte closes a frame and produces one transaction on
// the out_ channel: out_frame_ok plus the unpacked header and payload, all
// zero, the flag included, when the CRC residue is non-zero.
// Throughput: one byte per cycle while no closing byte waits behind an untaken
// result. Bytes pass an input register, then the counter/CRC/store update, which writes the result register.
// out_valid rises once the closing byte has passed the input register and
// loaded the result register; it waits while an earlier result is untaken.
// The output register decouples the sides: bytes keep flowing while a result
// waits; only a closing byte stalls behind an untaken result, and then
// in_ready drops until out_ready is seen.
// Reset clears the byte counter, the CRC and both valid flags; the header
// store is not cleared, as each frame rewrites it before it is read.
// ----------------------------------------------------------------------------
module crc8_packet_deframer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_frame_ok,
  output logic [15:0]               out_msg_type,
  output logic [7:0]                out_remote_flag,
  output logic [31:0]               out_msg_id,
  output logic [c8df_pkg::LEN_W-1:0] out_data_length,
  output logic [63:0]               out_payload
);
  import c8df_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  frame_res_t out_res_r;
  frame_res_t res;
  logic       frame_last;
  logic       out_free;
  logic       s1_adv;

  c8df_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (s1_adv),
    .byte_in    (s1_byte_r),
    .frame_last (frame_last),
    .res        (res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!frame_last || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && frame_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv && frame_last) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_res_r.frame_ok;
  assign out_msg_type    = out_res_r.msg_type;
  assign out_remote_flag = out_res_r.remote_flag;
  assign out_msg_id      = out_res_r.msg_id;
  assign out_data_length = out_res_r.data_length;
  assign out_payload     = out_res_r.payload;

`ifndef SYNTHESIS
  a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.frame_ok) |->
      (out_res_r.msg_type == '0 && out_res_r.msg_id == '0 && out_res_r.payload == '0))
    else $error("bad-CRC result carries non-zero fields");

  a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.data_length <= MAX_PAYLOAD))
    else $error("data length above clamp");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && frame_last && out_valid_r && !out_ready))
    else $error("input stalled without a pending result");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && frame_last) |=> out_valid_r)
    else $error("closing byte did not load a result");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc8_packet_deframer_core.
// ----------------------------------------------------------------------------
// Bytes are pushed in whole 17-byte frames. A handful of directed frames come
// first: extremes, bad CRC, length clamp and unused payload. Random frames
// follow, mostly with a correct CRC byte and random content, the rest with a
// corrupted CRC, random bytes or a good frame cut short by random filler.
// A behavioural frame tracker predicts each result (typed directed frames use
// a listed result); each out_ transaction is checked field by field against the
// oldest prediction. Both sides idle at random; the receiver also holds off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb;
  import c8df_pkg::*;

  localparam int IDLE_PCT   = 11;
  localparam int RAND_BYTES = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int N_DIR      = 11;

  typedef struct packed {
    logic [15:0] mtype;
    logic [7:0]  rflag;
    logic [31:0] mid;
    logic [7:0]  len_byte;
    logic [63:0] pay;
    logic [7:0]  crc_flip;
    logic        typed;
    frame_res_t  res;
  } frame_case_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic                out_frame_ok;
  logic [15:0]         out_msg_type;
  logic [7:0]          out_remote_flag;
  logic [31:0]         out_msg_id;
  logic [LEN_W-1:0]    out_data_length;
  logic [63:0]         out_payload;

  frame_res_t          frames_due[$];
  frame_case_t         dir_cases[N_DIR];
  frame_res_t          typed_res;
  logic                use_typed;

  logic [4:0]          trk_count;
  logic [7:0]          trk_crc;
  logic [7:0]          trk_store[16];

  int                  n_err;
  int                  n_sent;
  int                  n_results;
  logic                hold_done;

  crc8_packet_deframer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_ok    (out_frame_ok),
    .out_msg_type    (out_msg_type),
    .out_remote_flag (out_remote_flag),
    .out_msg_id      (out_msg_id),
    .out_data_length (out_data_length),
    .out_payload     (out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[crc8_packet_deframer_core] ERROR");
    $finish;
  end

  // reflected Maxim CRC-8, one byte, LSB first
  function automatic logic [7:0] maxim_crc_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    logic [7:0] c;
    logic [3:0] len;
    frame_res_t r;
    c = maxim_crc_step(trk_crc, b);
    if (trk_count < 5'd16) begin
      trk_store[trk_count[3:0]] = b;
    end
    if (trk_count != 5'd16) begin
      trk_count = trk_count + 5'd1;
      trk_crc   = c;
      return;
    end
    trk_count = '0;
    trk_crc   = '0;
    r = '0;
    if (c == 8'h00) begin
      len           = (trk_store[7] > 8'd8) ? 4'd8 : trk_store[7][3:0];
      r.frame_ok    = 1'b1;
      r.msg_type    = {trk_store[0], trk_store[1]};
      r.remote_flag = trk_store[2];
      r.msg_id      = {trk_store[3], trk_store[4], trk_store[5], trk_store[6]};
      r.data_length = len;
      for (int i = 0; i < 8; i++) begin
        if (i < len) r.payload[8*i +: 8] = trk_store[8 + i];
      end
    end
    frames_due.push_back(use_typed ? typed_res : r);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic steady;
    steady = (n_sent >= 600) && (n_sent < 900);
    while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_byte(b);
    n_sent++;
  endtask

  // cut < 17: good frame truncated, remainder filled with random bytes
  task automatic send_frame(input logic [15:0] mt, input logic [7:0] rf, input logic [31:0] id,
                            input logic [7:0] lb, input logic [63:0] pl,
                            input logic [7:0] flip, input int cut);
    logic [7:0] fb[17];
    logic [7:0] c;
    fb[0] = mt[15:8];
    fb[1] = mt[7:0];
    fb[2] = rf;
    fb[3] = id[31:24];
    fb[4] = id[23:16];
    fb[5] = id[15:8];
    fb[6] = id[7:0];
    fb[7] = lb;
    for (int i = 0; i < 8; i++) fb[8 + i] = pl[8*i +: 8];
    c = '0;
    for (int i = 0; i < 16; i++) c = maxim_crc_step(c, fb[i]);
    fb[16] = c ^ flip;
    for (int i = 0; i < 17; i++) send_byte((i < cut) ? fb[i] : 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  function automatic void cmp_field(input string fname, input logic [63:0] want_v,
                                    input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, fname, want_v, got_v);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : result_mon
    frame_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t unexpected result transaction: expected none actual ok=%b type=%h",
                 $time, out_frame_ok, out_msg_type);
        n_err++;
      end else begin
        want = frames_due.pop_front();
        cmp_field("frame_ok", 64'(want.frame_ok), 64'(out_frame_ok));
        cmp_field("msg_type", 64'(want.msg_type), 64'(out_msg_type));
        cmp_field("remote_flag", 64'(want.remote_flag), 64'(out_remote_flag));
        cmp_field("msg_id", 64'(want.msg_id), 64'(out_msg_id));
        cmp_field("data_length", 64'(want.data_length), 64'(out_data_length));
        cmp_field("payload", want.payload, out_payload);
      end
      n_results++;
    end
  end

  // receiver: random back-pressure, one long hold, one quiet stretch
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && (n_results >= 30)) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        out_ready <= ((n_results >= 60) && (n_results < 100)) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  initial begin
    int sel;
    int wait_cnt;
    logic [7:0] lb;

    n_err      = 0;
    n_sent     = 0;
    n_results  = 0;
    hold_done  = 1'b0;
    use_typed  = 1'b0;
    typed_res  = '0;
    trk_count  = '0;
    trk_crc    = '0;
    for (int i = 0; i < 16; i++) trk_store[i] = '0;

    dir_cases[0]  = '{16'h0000, 8'h00, 32'h0000_0000, 8'h00, 64'h0, 8'h00, 1'b1,
                      '{1'b1, 16'h0000, 8'h00, 32'h0000_0000, 4'd0, 64'h0}};
    dir_cases[1]  = '{16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, {64{1'b1}}, 8'h00, 1'b1,
                      '{1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'd8, {64{1'b1}}}};
    dir_cases[2]  = '{16'h0000, 8'h00, 32'h0000_0000, 8'h00, 64'h0, 8'h01, 1'b1, '0};
    dir_cases[3]  = '{16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, {64{1'b1}}, 8'h80, 1'b1, '0};
    dir_cases[4]  = '{16'h1234, 8'h01, 32'hDEAD_BEEF, 8'h00, 64'h1122_3344_5566_7788,
                      8'h00, 1'b1,
                      '{1'b1, 16'h1234, 8'h01, 32'hDEAD_BEEF, 4'd0, 64'h0}};
    dir_cases[5]  = '{16'hA55A, 8'h80, 32'h0102_0304, 8'h03, 64'h8877_6655_4433_2211,
                      8'h00, 1'b1,
                      '{1'b1, 16'hA55A, 8'h80, 32'h0102_0304, 4'd3, 64'h0000_0000_0033_2211}};
    dir_cases[6]  = '{16'h8000, 8'h7F, 32'h8000_0001, 8'h08, 64'hF0E1_D2C3_B4A5_9687,
                      8'h00, 1'b0, '0};
    dir_cases[7]  = '{16'h0001, 8'h55, 32'h7FFF_FFFE, 8'h09, 64'h0123_4567_89AB_CDEF,
                      8'h00, 1'b0, '0};
    dir_cases[8]  = '{16'h5AA5, 8'hAA, 32'h5555_AAAA, 8'h80, 64'hCAFE_F00D_1234_5678,
                      8'h00, 1'b0, '0};
    dir_cases[9]  = '{16'h00FF, 8'h3C, 32'h00FF_00FF, 8'h07, 64'hFF00_FF00_FF00_FF00,
                      8'h00, 1'b0, '0};
    dir_cases[10] = '{16'hC3C3, 8'h0F, 32'hF0F0_0F0F, 8'h01, 64'h0000_0000_0000_00FF,
                      8'h5A, 1'b0, '0};

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < N_DIR; n++) begin
      use_typed = dir_cases[n].typed;
      typed_res = dir_cases[n].res;
      send_frame(dir_cases[n].mtype, dir_cases[n].rflag, dir_cases[n].mid,
                 dir_cases[n].len_byte, dir_cases[n].pay, dir_cases[n].crc_flip, 17);
    end
    use_typed = 1'b0;

    // sender pause: let every result come out before the random traffic
    drain_results();

    while (n_sent < N_DIR * 17 + RAND_BYTES) begin
      sel = $urandom_range(0, 99);
      lb  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
      if (sel < 72) begin
        send_frame(16'($urandom), 8'($urandom), $urandom, lb, {$urandom, $urandom},
                   8'h00, 17);
      end else if (sel < 85) begin
        send_frame(16'($urandom), 8'($urandom), $urandom, lb, {$urandom, $urandom},
                   8'($urandom_range(1, 255)), 17);
      end else if (sel < 93) begin
        send_frame(16'($urandom), 8'($urandom), $urandom, lb, {$urandom, $urandom},
                   8'h00, 0);
      end else begin
        send_frame(16'($urandom), 8'($urandom), $urandom, lb, {$urandom, $urandom},
                   8'h00, $urandom_range(1, 16));
      end
    end

    in_valid <= 1'b0;
    wait_cnt = 0;
    while ((frames_due.size() != 0) && (wait_cnt < 5000)) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0t missing results: expected %0d more actual 0", $time, frames_due.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("[crc8_packet_deframer_core] OK");
    end else begin
      $display("[crc8_packet_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
